// ----- src/ps2hp_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2hp_pkg
// Shared types and constants for the PS/2 host port with receive ring.
// ----------------------------------------------------------------------------
package ps2hp_pkg;

    localparam int          DEFAULT_BUFFER_DEPTH = 1024;
    localparam int          QUEUE_DEPTH          = 4;
    localparam logic [15:0] INHIBIT_RESET        = 16'd1600;
    localparam logic [3:0]  FRAME_BITS           = 4'd11;
    localparam logic [3:0]  TX_DATA_BITS         = 4'd10;
    localparam logic [9:0]  AVAIL_MAX            = 10'd1023;

    typedef struct packed {
        logic       store;
        logic [7:0] frame_data;
        logic       send_done;
        logic       rreq;
        logic       rrep;
        logic       clk_low;
        logic       dat_low;
    } ps2hp_cmd_t;

    typedef struct packed {
        logic       clk_drive_low;
        logic       dat_drive_low;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       word_received;
        logic       send_done;
        logic [9:0] bytes_available;
    } ps2hp_res_t;

endpackage

// ----- src/ps2hp_fifo.sv -----
// ----------------------------------------------------------------------------
// ps2hp_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module ps2hp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       rd,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wr_idx_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [CW-1:0]    count_reg;

    assign rdata = store_reg[rd_idx_reg];
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            store_reg[wr_idx_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_idx_reg <= wr_idx_reg + 1'b1;
            end
            if (rd)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ----- src/ps2hp_front.sv -----
// ----------------------------------------------------------------------------
// ps2hp_front
// Line sequencer: receive shifting, send inhibit and bit drive per item.
// ----------------------------------------------------------------------------
module ps2hp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [15:0]           cfg_data,
    input  logic                  accept,
    input  logic                  clk_level,
    input  logic                  dat_level,
    input  logic                  send_request,
    input  logic [7:0]            send_byte,
    input  logic                  read_request,
    input  logic                  read_reply,
    output ps2hp_pkg::ps2hp_cmd_t cmd
);
    import ps2hp_pkg::*;

    typedef enum logic [2:0] {
        RX_LOW,
        RX_HIGH,
        TX_INH,
        TX_LOW,
        TX_HIGH
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [10:0] rx_shift_reg, rx_shift_next;
    logic [9:0]  tx_shift_reg, tx_shift_next;
    logic [15:0] inhibit_count_reg, inhibit_count_next;
    logic        pending_reg, pending_next;
    logic        clk_low_reg, clk_low_next;
    logic        dat_low_reg, dat_low_next;
    logic [15:0] inhibit_ticks_reg;
    logic [3:0]  bit_inc;
    logic        store;
    logic        done;

    assign bit_inc = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        rx_shift_next      = rx_shift_reg;
        tx_shift_next      = tx_shift_reg;
        inhibit_count_next = inhibit_count_reg;
        pending_next       = pending_reg;
        clk_low_next       = clk_low_reg;
        dat_low_next       = dat_low_reg;
        store              = 1'b0;
        done               = 1'b0;

        if (send_request && (phase_reg == RX_LOW || phase_reg == RX_HIGH))
        begin
            tx_shift_next = {1'b1, ~^send_byte, send_byte};
            pending_next  = 1'b1;
        end

        case (phase_reg)
            RX_LOW:
            begin
                if (pending_next)
                begin
                    pending_next       = 1'b0;
                    rx_shift_next      = '0;
                    bit_count_next     = '0;
                    clk_low_next       = 1'b1;
                    inhibit_count_next = inhibit_ticks_reg;
                    phase_next         = TX_INH;
                end
                else if (!clk_level)
                begin
                    rx_shift_next = {dat_level, rx_shift_reg[10:1]};
                    phase_next    = RX_HIGH;
                end
            end
            RX_HIGH:
            begin
                if (clk_level)
                begin
                    if (bit_inc >= FRAME_BITS)
                    begin
                        store          = 1'b1;
                        bit_count_next = '0;
                        rx_shift_next  = '0;
                    end
                    else
                    begin
                        bit_count_next = bit_inc;
                    end
                    phase_next = RX_LOW;
                end
            end
            TX_INH:
            begin
                if (inhibit_count_reg <= 16'd1)
                begin
                    inhibit_count_next = '0;
                    dat_low_next       = 1'b1;
                    clk_low_next       = 1'b0;
                    bit_count_next     = '0;
                    phase_next         = TX_LOW;
                end
                else
                begin
                    inhibit_count_next = inhibit_count_reg - 16'd1;
                end
            end
            TX_LOW:
            begin
                if (!clk_level)
                begin
                    if (bit_count_reg < TX_DATA_BITS)
                    begin
                        dat_low_next = ~tx_shift_reg[0];
                    end
                    phase_next = TX_HIGH;
                end
            end
            TX_HIGH:
            begin
                if (clk_level)
                begin
                    tx_shift_next = {1'b0, tx_shift_reg[9:1]};
                    if (bit_inc >= FRAME_BITS)
                    begin
                        bit_count_next = '0;
                        rx_shift_next  = '0;
                        dat_low_next   = 1'b0;
                        clk_low_next   = 1'b0;
                        done           = 1'b1;
                        phase_next     = RX_LOW;
                    end
                    else
                    begin
                        bit_count_next = bit_inc;
                        phase_next     = TX_LOW;
                    end
                end
            end
            default:
            begin
                phase_next = RX_LOW;
            end
        endcase

        cmd.store      = store;
        cmd.frame_data = rx_shift_reg[8:1];
        cmd.send_done  = done;
        cmd.rreq       = read_request;
        cmd.rrep       = read_reply;
        cmd.clk_low    = clk_low_next;
        cmd.dat_low    = dat_low_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= RX_LOW;
            bit_count_reg     <= '0;
            rx_shift_reg      <= '0;
            tx_shift_reg      <= '0;
            inhibit_count_reg <= '0;
            pending_reg       <= 1'b0;
            clk_low_reg       <= 1'b0;
            dat_low_reg       <= 1'b0;
            inhibit_ticks_reg <= INHIBIT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                inhibit_ticks_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg         <= phase_next;
                bit_count_reg     <= bit_count_next;
                rx_shift_reg      <= rx_shift_next;
                tx_shift_reg      <= tx_shift_next;
                inhibit_count_reg <= inhibit_count_next;
                pending_reg       <= pending_next;
                clk_low_reg       <= clk_low_next;
                dat_low_reg       <= dat_low_next;
            end
        end
    end
endmodule

// ----- src/ps2hp_back.sv -----
// ----------------------------------------------------------------------------
// ps2hp_back
// Receive ring: frame store, pointer updates, pops and result queue.
// ----------------------------------------------------------------------------
module ps2hp_back #(
    parameter int BUFFER_DEPTH = ps2hp_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  ps2hp_pkg::ps2hp_cmd_t cmd,
    output logic                  cmd_pop,
    output logic                  res_valid,
    output ps2hp_pkg::ps2hp_res_t res,
    input  logic                  res_pop
);
    import ps2hp_pkg::*;

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int AW = (PW + 1 > 10) ? PW + 1 : 10;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $bits(ps2hp_res_t);
    localparam logic [PW-1:0] LAST = PW'(BUFFER_DEPTH - 1);

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    mem_rd_reg;

    logic [PW-1:0] wp_reg, rp_reg, reply_reg;
    logic          split_reg;
    logic          s2_valid_reg, s2_hit_reg, s2_clk_reg, s2_dat_reg;
    logic          s2_word_reg, s2_done_reg;
    logic [9:0]    s2_avail_reg;

    logic [CW-1:0] oq_count;
    logic [RW-1:0] oq_rdata;
    ps2hp_res_t    s2_res;

    logic          issue, first_half, do_store, do_read;
    logic [PW-1:0] wp_inc, wp_after, reply_after, sel, sel_inc;
    logic [PW-1:0] rp_next, reply_next;
    logic          hit;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [PW:0]   diff;
    logic [AW-1:0] avail_wide;
    logic [9:0]    avail;

    always_comb
    begin
        issue      = cmd_valid
                     && ((CW + 1)'(oq_count) + (CW + 1)'(s2_valid_reg)
                         < (CW + 1)'(QUEUE_DEPTH));
        first_half = cmd.store && cmd.rreq && !split_reg;
        do_store   = issue && cmd.store && !split_reg;
        do_read    = issue && !first_half;

        wp_inc      = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
        wp_after    = do_store ? wp_inc : wp_reg;
        reply_after = (do_read && cmd.send_done) ? wp_after : reply_reg;
        sel         = cmd.rrep ? reply_after : rp_reg;
        sel_inc     = (sel == LAST) ? '0 : sel + 1'b1;
        hit         = do_read && cmd.rreq && (sel != wp_after);
        rp_next     = (hit && !cmd.rrep) ? sel_inc : rp_reg;
        reply_next  = (hit && cmd.rrep) ? sel_inc : reply_after;

        mem_we    = do_store || (hit && cmd.rrep);
        mem_waddr = do_store ? wp_reg : sel;
        mem_wdata = do_store ? cmd.frame_data : 8'd0;

        diff = {1'b0, wp_after} - {1'b0, rp_next};
        if (wp_after < rp_next)
        begin
            diff = diff + (PW + 1)'(BUFFER_DEPTH);
        end
        avail_wide = AW'(diff);
        avail      = (avail_wide > AW'(AVAIL_MAX)) ? AVAIL_MAX : avail_wide[9:0];
    end

    assign cmd_pop = do_read;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (hit)
        begin
            mem_rd_reg <= mem[sel];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            reply_reg    <= '0;
            split_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_hit_reg   <= 1'b0;
            s2_clk_reg   <= 1'b0;
            s2_dat_reg   <= 1'b0;
            s2_word_reg  <= 1'b0;
            s2_done_reg  <= 1'b0;
            s2_avail_reg <= '0;
        end
        else
        begin
            wp_reg       <= wp_after;
            rp_reg       <= rp_next;
            reply_reg    <= reply_next;
            split_reg    <= issue ? first_half : split_reg;
            s2_valid_reg <= do_read;
            if (do_read)
            begin
                s2_hit_reg   <= hit;
                s2_clk_reg   <= cmd.clk_low;
                s2_dat_reg   <= cmd.dat_low;
                s2_word_reg  <= cmd.store;
                s2_done_reg  <= cmd.send_done;
                s2_avail_reg <= avail;
            end
        end
    end

    always_comb
    begin
        s2_res.clk_drive_low   = s2_clk_reg;
        s2_res.dat_drive_low   = s2_dat_reg;
        s2_res.read_byte       = s2_hit_reg ? mem_rd_reg : 8'd0;
        s2_res.read_valid      = |s2_res.read_byte;
        s2_res.word_received   = s2_word_reg;
        s2_res.send_done       = s2_done_reg;
        s2_res.bytes_available = s2_avail_reg;
    end

    ps2hp_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (s2_valid_reg),
        .wdata (s2_res),
        .rd    (res_pop),
        .rdata (oq_rdata),
        .count (oq_count)
    );

    assign res_valid = (oq_count != '0);
    assign res       = ps2hp_res_t'(oq_rdata);
endmodule

// ----- src/ps2_host_port_with_rx_ring.sv -----
// Path: an accepted item passes the command queue, the ring stage and its
// result registers, then the result queue. Throughput: one item per cycle while
// the result queue has room; an item that both stores a frame and pops is split
// in the ring stage into a store and then a pop (one frame memory write port).
// Reset: asynchronous, active low; line sequencer idles in receive, ring
// pointers are zero, frame memory contents stay undefined (no clearing pass).
// ----------------------------------------------------------------------------
// ps2_host_port_with_rx_ring
// PS/2 host port: line sequencer, command queue and receive ring.
// ----------------------------------------------------------------------------
module ps2_host_port_with_rx_ring #(
    parameter int BUFFER_DEPTH = ps2hp_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        clk_level,
    input  logic        dat_level,
    input  logic        send_request,
    input  logic [7:0]  send_byte,
    input  logic        read_request,
    input  logic        read_reply,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic        clk_drive_low,
    output logic        dat_drive_low,
    output logic        read_valid,
    output logic [7:0]  read_byte,
    output logic        word_received,
    output logic        send_done,
    output logic [9:0]  bytes_available
);
    import ps2hp_pkg::*;

    localparam int CMD_W = $bits(ps2hp_cmd_t);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    logic             accept;
    ps2hp_cmd_t       cmd_in;
    logic [CMD_W-1:0] cmd_q;
    logic [CW-1:0]    cmd_count;
    logic             cmd_pop;
    logic             res_valid;
    ps2hp_res_t       res;

    assign full   = (cmd_count == CW'(QUEUE_DEPTH));
    assign accept = push && !full;

    ps2hp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .clk_level    (clk_level),
        .dat_level    (dat_level),
        .send_request (send_request),
        .send_byte    (send_byte),
        .read_request (read_request),
        .read_reply   (read_reply),
        .cmd          (cmd_in)
    );

    ps2hp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (cmd_in),
        .rd    (cmd_pop),
        .rdata (cmd_q),
        .count (cmd_count)
    );

    ps2hp_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_count != '0),
        .cmd       (ps2hp_cmd_t'(cmd_q)),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop && res_valid)
    );

    assign empty           = !res_valid;
    assign clk_drive_low   = res.clk_drive_low;
    assign dat_drive_low   = res.dat_drive_low;
    assign read_valid      = res.read_valid;
    assign read_byte       = res.read_byte;
    assign word_received   = res.word_received;
    assign send_done       = res.send_done;
    assign bytes_available = res.bytes_available;

`ifndef SYNTHESIS
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && read_valid) |-> (read_byte != 8'd0))
        else $error("read_valid with zero byte");

    a_store_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(word_received && send_done))
        else $error("frame store and send completion in one item");

    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(clk_drive_low && dat_drive_low))
        else $error("clock and data both driven low");
`endif
endmodule
